// ===== hdl/clock_power_manager_registers_assert.svh =====
// Assertion helpers for the clock and power manager register file.
`ifndef CLOCK_POWER_MANAGER_REGISTERS_ASSERT_SVH
`define CLOCK_POWER_MANAGER_REGISTERS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpm assertion failed");

// Next-cycle implication, checked outside reset.
`define CPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpm assertion failed");

`endif

// ===== hdl/cpm_pkg.sv =====
package cpm_pkg;

	localparam int PROG_CLOCKS_DEF = 4;
	localparam int PROG_CLOCKS_MAX = 4;

	localparam int XIN_W  = 27;
	localparam int WORD_W = 5;
	localparam int DATA_W = 32;
	localparam int SYS_W  = 12;
	localparam int OSC_W  = 16;
	localparam int PCK_W  = 5;
	localparam int FLAG_W = 12;

	// register word offsets
	localparam logic [WORD_W-1:0] RW_SCER  = 5'd0;
	localparam logic [WORD_W-1:0] RW_SCDR  = 5'd1;
	localparam logic [WORD_W-1:0] RW_SCSR  = 5'd2;
	localparam logic [WORD_W-1:0] RW_PCER  = 5'd4;
	localparam logic [WORD_W-1:0] RW_PCDR  = 5'd5;
	localparam logic [WORD_W-1:0] RW_PCSR  = 5'd6;
	localparam logic [WORD_W-1:0] RW_MOR   = 5'd8;
	localparam logic [WORD_W-1:0] RW_MCFR  = 5'd9;
	localparam logic [WORD_W-1:0] RW_PLLA  = 5'd10;
	localparam logic [WORD_W-1:0] RW_PLLB  = 5'd11;
	localparam logic [WORD_W-1:0] RW_MCKR  = 5'd12;
	localparam logic [WORD_W-1:0] RW_PCK0  = 5'd16;
	localparam logic [WORD_W-1:0] RW_IER   = 5'd24;
	localparam logic [WORD_W-1:0] RW_IDR   = 5'd25;
	localparam logic [WORD_W-1:0] RW_SR    = 5'd26;
	localparam logic [WORD_W-1:0] RW_IMR   = 5'd27;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	localparam logic [SYS_W-1:0]  SYS_EN_MASK = 12'hf17;
	localparam logic [FLAG_W-1:0] IRQ_EN_MASK = 12'hf0f;
	localparam logic [OSC_W-1:0]  OSC_MASK    = 16'hff01;
	localparam logic [PCK_W-1:0]  PCK_MASK    = 5'h1f;

	localparam int SLOW_CLOCK_HZ = 32768;
	localparam int FREQ_SHIFT    = $clog2(SLOW_CLOCK_HZ / 16);
	localparam logic [DATA_W-1:0] MAINRDY_BIT = 32'h0001_0000;

	localparam logic [XIN_W-1:0]  XIN_DEFAULT = 27'd18432000;
	localparam logic [SYS_W-1:0]  SYS_RESET   = 12'h001;
	localparam logic [DATA_W-1:0] PLL_RESET   = 32'h0000_3f00;
	localparam logic [FLAG_W-1:0] SR_RESET    = 12'hf08;

	// status flag positions
	localparam int FLAG_OSC    = 0;
	localparam int FLAG_LOCKA  = 1;
	localparam int FLAG_LOCKB  = 2;
	localparam int FLAG_MCKRDY = 3;
	localparam int FLAG_PCK0   = 8;

endpackage

// ===== hdl/cpm_if.sv =====
interface cpm_req_if import cpm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [WORD_W-1:0] reg_word;
	logic [DATA_W-1:0] write_data;

	modport source (output valid, output mode, output reg_word, output write_data,
		input ready);
	modport sink (input valid, input mode, input reg_word, input write_data,
		output ready);
endinterface

interface cpm_rsp_if import cpm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              irq;

	modport source (output valid, output read_data, output irq, input ready);
	modport sink (input valid, input read_data, input irq, output ready);
endinterface

// ===== hdl/clock_power_manager_registers.sv =====
// Channel  Direction  Beat contents
// req      in         mode, reg_word, write_data
// rsp      out        read_data, irq
// cfg      in         cfg_we, cfg_data (xin_hz)
//
// One beat per cycle while rsp is not stalled; an access passes from req to rsp via the
// input register, then one pass of decode and masked update into the result register.
// The register file updates at the edge the result is loaded, so the next access sees it.
// A stalled rsp holds the result; req keeps flowing until the input register also fills.
// arst_n clears the handshake state and loads the register file and xin_q with their reset values.
module clock_power_manager_registers import cpm_pkg::*; #(
	parameter int PROG_CLOCKS = PROG_CLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	cpm_req_if.sink          req,
	cpm_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [XIN_W-1:0] cfg_data
);

	logic              valid_s1;
	logic              mode_s1;
	logic [WORD_W-1:0] word_s1;
	logic [DATA_W-1:0] wdata_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] rdata_q;
	logic              irq_q;

	logic [XIN_W-1:0]  xin_q;
	logic [SYS_W-1:0]  sys_q,   sys_d;
	logic [DATA_W-1:0] per_q,   per_d;
	logic [OSC_W-1:0]  osc_q,   osc_d;
	logic [DATA_W-1:0] plla_q,  plla_d;
	logic [DATA_W-1:0] pllb_q,  pllb_d;
	logic [DATA_W-1:0] mck_q,   mck_d;
	logic [PCK_W-1:0]  pck_q [PROG_CLOCKS];
	logic [PCK_W-1:0]  pck_d [PROG_CLOCKS];
	logic [FLAG_W-1:0] stat_q,  stat_d;
	logic [FLAG_W-1:0] mask_q,  mask_d;
	logic [DATA_W-1:0] rdata_d;

	logic advance;
	logic fire;
	logic is_wr;

	assign advance = !out_valid_q || rsp.ready;
	assign fire    = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign is_wr   = (mode_s1 == MODE_WRITE);

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = rdata_q;
	assign rsp.irq       = irq_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1  <= req.mode;
			word_s1  <= req.reg_word;
			wdata_s1 <= req.write_data;
		end
	end

	// decode, read mux and next register state
	always_comb begin
		sys_d   = sys_q;
		per_d   = per_q;
		osc_d   = osc_q;
		plla_d  = plla_q;
		pllb_d  = pllb_q;
		mck_d   = mck_q;
		stat_d  = stat_q;
		mask_d  = mask_q;
		rdata_d = '0;
		for (int n = 0; n < PROG_CLOCKS; n++) begin
			pck_d[n] = pck_q[n];
		end

		if (is_wr) begin
			case (word_s1)
				RW_SCER: sys_d = sys_q | (wdata_s1[SYS_W-1:0] & SYS_EN_MASK);
				RW_SCDR: sys_d = sys_q & ~(wdata_s1[SYS_W-1:0] & SYS_EN_MASK);
				RW_PCER: per_d = per_q | wdata_s1;
				RW_PCDR: per_d = per_q & ~wdata_s1;
				RW_MOR: begin
					osc_d = wdata_s1[OSC_W-1:0] & OSC_MASK;
					stat_d[FLAG_OSC] = wdata_s1[0];
				end
				RW_PLLA: begin
					plla_d = wdata_s1;
					stat_d[FLAG_LOCKA] = |wdata_s1[7:0];
				end
				RW_PLLB: begin
					pllb_d = wdata_s1;
					stat_d[FLAG_LOCKB] = |wdata_s1[7:0];
				end
				RW_MCKR: begin
					mck_d = wdata_s1;
					stat_d[FLAG_MCKRDY] = 1'b1;
				end
				RW_IER:  mask_d = mask_q | (wdata_s1[FLAG_W-1:0] & IRQ_EN_MASK);
				RW_IDR:  mask_d = mask_q & ~(wdata_s1[FLAG_W-1:0] & IRQ_EN_MASK);
				default: ;
			endcase
			// programmable clock ready flags track their system enable bits
			for (int n = 0; n < PROG_CLOCKS; n++) begin
				if (word_s1 == RW_SCER || word_s1 == RW_SCDR) begin
					stat_d[FLAG_PCK0+n] = sys_d[FLAG_PCK0+n];
				end
				if (word_s1 == RW_PCK0 + WORD_W'(n)) begin
					pck_d[n] = wdata_s1[PCK_W-1:0] & PCK_MASK;
					stat_d[FLAG_PCK0+n] = sys_q[FLAG_PCK0+n];
				end
			end
		end else begin
			case (word_s1)
				RW_SCSR: rdata_d = DATA_W'(sys_q);
				RW_PCSR: rdata_d = per_q;
				RW_MOR:  rdata_d = DATA_W'(osc_q);
				RW_MCFR: begin
					if (osc_q[0]) begin
						rdata_d = DATA_W'(xin_q >> FREQ_SHIFT) | MAINRDY_BIT;
					end
				end
				RW_PLLA: rdata_d = plla_q;
				RW_PLLB: rdata_d = pllb_q;
				RW_MCKR: rdata_d = mck_q;
				RW_SR:   rdata_d = DATA_W'(stat_q);
				RW_IMR:  rdata_d = DATA_W'(mask_q);
				default: rdata_d = '0;
			endcase
			for (int n = 0; n < PROG_CLOCKS; n++) begin
				if (word_s1 == RW_PCK0 + WORD_W'(n)) begin
					rdata_d = DATA_W'(pck_q[n]);
				end
			end
		end
	end

	// register file, committed as the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_q  <= SYS_RESET;
			per_q  <= '0;
			osc_q  <= '0;
			plla_q <= PLL_RESET;
			pllb_q <= PLL_RESET;
			mck_q  <= '0;
			stat_q <= SR_RESET;
			mask_q <= '0;
			for (int n = 0; n < PROG_CLOCKS; n++) begin
				pck_q[n] <= '0;
			end
		end else if (fire) begin
			sys_q  <= sys_d;
			per_q  <= per_d;
			osc_q  <= osc_d;
			plla_q <= plla_d;
			pllb_q <= pllb_d;
			mck_q  <= mck_d;
			stat_q <= stat_d;
			mask_q <= mask_d;
			for (int n = 0; n < PROG_CLOCKS; n++) begin
				pck_q[n] <= pck_d[n];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xin_q <= XIN_DEFAULT;
		end else if (cfg_we) begin
			xin_q <= cfg_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rdata_q <= is_wr ? '0 : rdata_d;
			irq_q   <= |(stat_d & mask_d);
		end
	end

`include "clock_power_manager_registers_assert.svh"

	// the held result's irq always matches the committed registers
	`CPM_ASSERT_IMPL(a_irq_consistent, clk, arst_n, out_valid_q, irq_q == |(stat_q & mask_q))
	// only reserved-free flag and mask bits ever get set
	`CPM_ASSERT_IMPL(a_no_reserved, clk, arst_n, 1'b1, stat_q[7:4] == '0 && (mask_q & ~IRQ_EN_MASK) == '0)
	// oscillator stable flag mirrors the stored enable bit
	`CPM_ASSERT_IMPL(a_osc_flag, clk, arst_n, 1'b1, stat_q[FLAG_OSC] == osc_q[0])
	// back-pressure reaches req only when both stages are full
	`CPM_ASSERT_IMPL(a_ready_low, clk, arst_n, !req.ready, valid_s1 && out_valid_q && !rsp.ready)
	// a stalled access keeps the registers unchanged
	`CPM_ASSERT_NEXT(a_stall_hold, clk, arst_n, !fire, $stable(stat_q) && $stable(mask_q))

endmodule

// ===== tb/cpm_access_checker.sv =====
`timescale 1ns / 1ps

module cpm_access_checker import cpm_pkg::*; #(
	parameter int PROG_CLOCKS = PROG_CLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	cpm_req_if               req,
	cpm_rsp_if               rsp,
	input  logic             cfg_we,
	input  logic [XIN_W-1:0] cfg_data,
	output int               fail_count,
	output int               outstanding
);

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq;
	} access_result_t;

	access_result_t pending_responses[$];
	int errors = 0;

	logic [XIN_W-1:0]  xin;
	logic [SYS_W-1:0]  sys_enables;
	logic [DATA_W-1:0] periph_enables;
	logic [OSC_W-1:0]  osc_setting;
	logic [DATA_W-1:0] pll_a;
	logic [DATA_W-1:0] pll_b;
	logic [DATA_W-1:0] mck_setting;
	logic [PCK_W-1:0]  pck_setting[PROG_CLOCKS_MAX];
	logic [FLAG_W-1:0] flags;
	logic [FLAG_W-1:0] irq_mask;

	// ready flag of each programmable clock in [lo, hi) follows its enable bit
	task automatic copy_pck_ready(input int lo, input int hi);
		for (int n = lo; n < hi; n++)
			flags[FLAG_PCK0 + n] = sys_enables[FLAG_PCK0 + n];
	endtask

	task automatic apply_bus_access(input logic mode, input logic [WORD_W-1:0] word,
		input logic [DATA_W-1:0] data, output access_result_t res);
		logic [DATA_W-1:0] rd;
		int idx;
		rd = '0;
		idx = int'(word) - int'(RW_PCK0);
		if (mode == MODE_WRITE) begin
			case (word)
				RW_SCER: begin
					sys_enables |= data[SYS_W-1:0] & SYS_EN_MASK;
					copy_pck_ready(0, PROG_CLOCKS);
				end
				RW_SCDR: begin
					sys_enables &= ~(data[SYS_W-1:0] & SYS_EN_MASK);
					copy_pck_ready(0, PROG_CLOCKS);
				end
				RW_PCER: periph_enables |= data;
				RW_PCDR: periph_enables &= ~data;
				RW_MOR: begin
					osc_setting = data[OSC_W-1:0] & OSC_MASK;
					flags[FLAG_OSC] = data[0];
				end
				RW_PLLA: begin
					pll_a = data;
					flags[FLAG_LOCKA] = (data[7:0] != 8'd0);
				end
				RW_PLLB: begin
					pll_b = data;
					flags[FLAG_LOCKB] = (data[7:0] != 8'd0);
				end
				RW_MCKR: begin
					mck_setting = data;
					flags[FLAG_MCKRDY] = 1'b1;
				end
				RW_IER: irq_mask |= data[FLAG_W-1:0] & IRQ_EN_MASK;
				RW_IDR: irq_mask &= ~(data[FLAG_W-1:0] & IRQ_EN_MASK);
				default: begin
					if (idx >= 0 && idx < PROG_CLOCKS) begin
						pck_setting[idx] = data[PCK_W-1:0] & PCK_MASK;
						copy_pck_ready(idx, idx + 1);
					end
				end
			endcase
		end else begin
			case (word)
				RW_SCSR: rd = DATA_W'(sys_enables);
				RW_PCSR: rd = periph_enables;
				RW_MOR:  rd = DATA_W'(osc_setting);
				RW_MCFR: begin
					if (osc_setting[0])
						rd = DATA_W'((64'(xin) * 16) / SLOW_CLOCK_HZ) | MAINRDY_BIT;
				end
				RW_PLLA: rd = pll_a;
				RW_PLLB: rd = pll_b;
				RW_MCKR: rd = mck_setting;
				RW_SR:   rd = DATA_W'(flags);
				RW_IMR:  rd = DATA_W'(irq_mask);
				default: begin
					if (idx >= 0 && idx < PROG_CLOCKS)
						rd = DATA_W'(pck_setting[idx]);
				end
			endcase
		end
		res.read_data = rd;
		res.irq = |(flags & irq_mask);
	endtask

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		if (!arst_n) begin
			xin = XIN_DEFAULT;
			sys_enables = SYS_RESET;
			periph_enables = '0;
			osc_setting = '0;
			pll_a = PLL_RESET;
			pll_b = PLL_RESET;
			mck_setting = '0;
			for (int n = 0; n < PROG_CLOCKS_MAX; n++)
				pck_setting[n] = '0;
			flags = SR_RESET;
			irq_mask = '0;
			pending_responses.delete();
		end else begin
			if (cfg_we)
				xin = cfg_data;
			if (rsp.valid && rsp.ready) begin
				if (pending_responses.size() == 0) begin
					$error("response beat with nothing expected: read_data %h irq %b",
						rsp.read_data, rsp.irq);
					errors++;
				end else begin
					want = pending_responses.pop_front();
					if (rsp.read_data !== want.read_data) begin
						$error("read_data: expected %h, actual %h", want.read_data,
							rsp.read_data);
						errors++;
					end
					if (rsp.irq !== want.irq) begin
						$error("irq: expected %b, actual %b", want.irq, rsp.irq);
						errors++;
					end
				end
			end
			if (req.valid && req.ready) begin
				apply_bus_access(req.mode, req.reg_word, req.write_data, want);
				pending_responses.push_back(want);
			end
		end
		fail_count <= errors;
		outstanding <= pending_responses.size();
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench import cpm_pkg::*;;

	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 300;
	localparam int STALL_LIMIT = 2000;

	// an offset with no register behind it
	localparam logic [WORD_W-1:0] RW_UNMAPPED = 5'd31;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             cfg_we;
	logic [XIN_W-1:0] cfg_data;
	int               fail_count;
	int               outstanding;
	bit               quiet = 1'b0;
	bit               hold_rsp = 1'b0;
	int               idle_cycles;

	cpm_req_if req_ch();
	cpm_rsp_if rsp_ch();

	clock_power_manager_registers DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch.sink),
		.rsp      (rsp_ch.source),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	cpm_access_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_access(input logic mode, input logic [WORD_W-1:0] word,
		input logic [DATA_W-1:0] data);
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.reg_word <= word;
		req_ch.write_data <= data;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// drop valid and hold until every response is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_xin(input logic [XIN_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// response side: short random stalls, plus one long hold on request
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (60) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		logic [XIN_W-1:0]  xin_set[PHASES];
		logic              mode;
		logic [WORD_W-1:0] word;
		logic [DATA_W-1:0] data;

		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_READ;
		req_ch.reg_word <= '0;
		req_ch.write_data <= '0;
		cfg_we <= 1'b0;
		cfg_data <= XIN_DEFAULT;
		xin_set = '{27'd0, 27'd100000000, 27'd2047, XIN_W'($urandom_range(0, 100000000)),
			27'd2048, XIN_DEFAULT};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// prog clock ready flags start set while their enables are clear
		send_access(MODE_READ, RW_SR, '0);
		send_access(MODE_READ, RW_SCSR, '0);
		send_access(MODE_READ, RW_PLLA, '0);
		send_access(MODE_READ, RW_MCFR, '0);
		send_access(MODE_WRITE, RW_MOR, '1);
		send_access(MODE_READ, RW_MCFR, '0);
		send_access(MODE_WRITE, RW_IER, '1);
		send_access(MODE_READ, RW_IMR, '0);
		send_access(MODE_WRITE, RW_PLLA, '0);
		send_access(MODE_WRITE, RW_PLLB, '1);
		send_access(MODE_WRITE, RW_MCKR, '1);
		send_access(MODE_WRITE, RW_SCER, '1);
		send_access(MODE_WRITE, RW_PCK0 + 5'd3, '1);
		send_access(MODE_READ, RW_PCK0 + 5'd3, '0);
		send_access(MODE_WRITE, RW_SCDR, '1);
		send_access(MODE_WRITE, RW_PCK0 + 5'd1, '0);
		send_access(MODE_READ, RW_SR, '0);
		send_access(MODE_WRITE, RW_PCER, '1);
		send_access(MODE_WRITE, RW_PCDR, 32'haaaa_aaaa);
		send_access(MODE_READ, RW_PCSR, '0);
		send_access(MODE_WRITE, RW_SR, '1);
		send_access(MODE_READ, RW_SCER, '0);
		send_access(MODE_WRITE, RW_UNMAPPED, '1);
		send_access(MODE_READ, RW_UNMAPPED, '0);
		send_access(MODE_WRITE, RW_IDR, '1);
		send_access(MODE_WRITE, RW_MOR, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_xin(xin_set[ph]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long receiver hold while requests keep coming
				if (ph == 1 && i == 50)
					hold_rsp = 1'b1;
				if (ph == PHASES - 1 && i == PHASE_ITEMS / 2)
					quiet = 1'b1;
				mode = 1'($urandom_range(0, 1));
				word = WORD_W'($urandom_range(0, 31));
				case ($urandom_range(0, 7))
					0: data = '0;
					1: data = '1;
					2: data = $urandom & 32'hffff_ff00;
					default: data = $urandom;
				endcase
				send_access(mode, word, data);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cpm_pkg.sv
hdl/cpm_if.sv
hdl/clock_power_manager_registers.sv
tb/cpm_access_checker.sv
tb/testbench.sv
